### sv/aabb_pkg.sv
// Shared types, constants and helpers for the box transform block.
`default_nettype none
package aabb_pkg;
	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS = 8;
	localparam int IDX_W = 64;
	// Divider: quotient of a 49-bit dividend; one bit per stage.
	localparam int DIV_BITS = 32 + FRAC_BITS + 1;
	localparam int LAT = DIV_BITS + 5;

	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	localparam logic [2:0] REG_M11_M12 = 3'd0;
	localparam logic [2:0] REG_M13_M14 = 3'd1;
	localparam logic [2:0] REG_M21_M22 = 3'd2;
	localparam logic [2:0] REG_M23_M24 = 3'd3;
	localparam logic [2:0] REG_M31_M32 = 3'd4;
	localparam logic [2:0] REG_M33_M34 = 3'd5;
	localparam logic [2:0] REG_M41_M42 = 3'd6;
	localparam logic [2:0] REG_M43_M44 = 3'd7;

	typedef logic signed [31:0] q_t;
	typedef logic signed [33:0] acc_t;

	// Saturate a wide signed value to 32 bits; report a clamp.
	function automatic q_t sat32(input logic signed [67:0] v, output logic hit);
		hit = 1'b0;
		if (v > 68'sd2147483647) begin
			hit = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -68'sd2147483648) begin
			hit = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

### sv/aabb_lane.sv
// One output axis: transformed coordinate, center division, extent and bounds.
`default_nettype none
module aabb_lane
	import aabb_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    adv,
	input  wire logic signed [31:0]      c_x,
	input  wire logic signed [31:0]      c_y,
	input  wire logic signed [31:0]      c_z,
	input  wire logic signed [31:0]      e_x,
	input  wire logic signed [31:0]      e_y,
	input  wire logic signed [31:0]      e_z,
	input  wire logic signed [31:0]      m1,
	input  wire logic signed [31:0]      m2,
	input  wire logic signed [31:0]      m3,
	input  wire logic signed [31:0]      m4,
	input  wire logic signed [31:0]      w_in,
	input  wire logic                    w_zero_in,
	output q_t                           p_out,
	output logic                         p_sat,
	output q_t                           lo,
	output q_t                           hi,
	output logic                         sat
);
	localparam int DW = DIV_BITS;
	localparam int RW = 34;

	// stage 1: six products
	logic signed [63:0] pc1_s1, pc2_s1, pc3_s1, pe1_s1, pe2_s1, pe3_s1;
	logic signed [31:0] m4_s1;
	logic signed [32:0] a1, a2, a3;
	assign a1 = m1[31] ? -33'(m1) : 33'(m1);
	assign a2 = m2[31] ? -33'(m2) : 33'(m2);
	assign a3 = m3[31] ? -33'(m3) : 33'(m3);
	always_ff @(posedge clk) begin
		if (adv) begin
			pc1_s1 <= 64'(c_x * m1);
			pc2_s1 <= 64'(c_y * m2);
			pc3_s1 <= 64'(c_z * m3);
			pe1_s1 <= 64'($signed(a1) * 64'(e_x));
			pe2_s1 <= 64'($signed(a2) * 64'(e_y));
			pe3_s1 <= 64'($signed(a3) * 64'(e_z));
			m4_s1  <= m4;
		end
	end

	// stage 2: shifted sums
	logic signed [67:0] ps, es;
	q_t p_c;
	logic psat_c;
	always_comb begin
		ps = 68'(m4_s1) + 68'(pc1_s1 >>> FRAC_BITS) + 68'(pc2_s1 >>> FRAC_BITS)
			+ 68'(pc3_s1 >>> FRAC_BITS);
		es = 68'(pe1_s1 >>> FRAC_BITS) + 68'(pe2_s1 >>> FRAC_BITS)
			+ 68'(pe3_s1 >>> FRAC_BITS);
		p_c = sat32(ps, psat_c);
	end
	q_t p_s2;
	logic signed [67:0] ext_s2;
	logic psat_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= p_c;
			psat_s2 <= psat_c;
			ext_s2 <= es;
		end
	end
	assign p_out = p_s2;
	assign p_sat = psat_s2;

	// divider pipeline, one quotient bit per stage on magnitudes
	logic [DW-1:0] n_q [DW+1];
	logic [RW-1:0] r_q [DW+1];
	logic [DW-1:0] q_q [DW+1];
	logic [31:0]   d_q [DW+1];
	logic          neg_q [DW+1];
	logic          wz_q [DW+1];
	q_t            p_q [DW+1];
	logic          ps_q [DW+1];
	logic signed [67:0] ex_q [DW+1];

	logic [31:0] pmag, wmag;
	assign pmag = p_s2[31] ? 32'(-p_s2) : 32'(p_s2);
	assign wmag = w_in[31] ? 32'(-w_in) : 32'(w_in);

	// w and wz arrive with p (stage 2 outputs from top)
	always_ff @(posedge clk) begin
		if (adv) begin
			n_q[0]   <= {1'b0, pmag, {FRAC_BITS{1'b0}}};
			r_q[0]   <= '0;
			q_q[0]   <= '0;
			d_q[0]   <= wmag;
			neg_q[0] <= p_s2[31] ^ w_in[31];
			wz_q[0]  <= w_zero_in;
			p_q[0]   <= p_s2;
			ps_q[0]  <= psat_s2;
			ex_q[0]  <= ext_s2;
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [RW-1:0] rt;
		logic          ge;
		assign rt = {r_q[k][RW-2:0], n_q[k][DW-1-k]};
		assign ge = rt >= RW'(d_q[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				r_q[k+1]   <= ge ? rt - RW'(d_q[k]) : rt;
				q_q[k+1]   <= q_q[k] | (DW'(ge) << (DW-1-k));
				n_q[k+1]   <= n_q[k];
				d_q[k+1]   <= d_q[k];
				neg_q[k+1] <= neg_q[k];
				wz_q[k+1]  <= wz_q[k];
				p_q[k+1]   <= p_q[k];
				ps_q[k+1]  <= ps_q[k];
				ex_q[k+1]  <= ex_q[k];
			end
		end
	end

	// final stage: center, bounds
	logic signed [67:0] qs, ctr, lv, hv;
	logic qsat, ctr_sat, ls, hs;
	q_t ctr32, lo_c, hi_c, lo_s3, hi_s3;
	logic sat_s3;
	always_comb begin
		qs = neg_q[DW] ? -68'(q_q[DW]) : 68'(q_q[DW]);
		ctr32 = sat32(qs, qsat);
		ctr_sat = qsat & ~wz_q[DW];
		ctr = wz_q[DW] ? 68'(p_q[DW]) : 68'(ctr32);
		lv = ctr - ex_q[DW];
		hv = ctr + ex_q[DW];
		lo_c = sat32(lv, ls);
		hi_c = sat32(hv, hs);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s3 <= lo_c;
			hi_s3 <= hi_c;
			sat_s3 <= ctr_sat | ps_q[DW] | ls | hs;
		end
	end
	assign lo = lo_s3;
	assign hi = hi_s3;
	assign sat = sat_s3;
endmodule
`default_nettype wire

### sv/aabb_affine_transform.sv
// Top level: box transform with three axis lanes, a w lane and merge.
// Input and result words are Q16.16.
// Throughput: one box per cycle; the pipeline stalls as a whole on backpressure.
// The center division is a pipelined restoring divider, one quotient bit a stage.
// Reset restores the identity matrix and empties the pipeline.
`default_nettype none
module aabb_affine_transform
	import aabb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire q_t          min_x,
	input  wire q_t          min_y,
	input  wire q_t          min_z,
	input  wire q_t          max_x,
	input  wire q_t          max_y,
	input  wire q_t          max_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output q_t               out_min_x,
	output q_t               out_min_y,
	output q_t               out_min_z,
	output q_t               out_max_x,
	output q_t               out_max_y,
	output q_t               out_max_z,
	output logic             saturated,
	output logic             w_zero
);
	logic [63:0] m_q [NUM_REGS];
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q[REG_M11_M12] <= ONE;
			m_q[REG_M13_M14] <= '0;
			m_q[REG_M21_M22] <= ONE << 32;
			m_q[REG_M23_M24] <= '0;
			m_q[REG_M31_M32] <= '0;
			m_q[REG_M33_M34] <= ONE;
			m_q[REG_M41_M42] <= '0;
			m_q[REG_M43_M44] <= ONE << 32;
		end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
			m_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// valid shift line; whole pipe advances unless the output word is held
	logic [LAT-1:0] v_q;
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign out_valid = v_q[LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[LAT-2:0], in_valid};
	end

	// stage 0: center and half extent
	q_t c_s0 [3];
	q_t e_s0 [3];
	logic signed [32:0] s [3], d [3];
	assign s[0] = 33'(min_x) + 33'(max_x);
	assign s[1] = 33'(min_y) + 33'(max_y);
	assign s[2] = 33'(min_z) + 33'(max_z);
	assign d[0] = 33'(max_x) - 33'(min_x);
	assign d[1] = 33'(max_y) - 33'(min_y);
	assign d[2] = 33'(max_z) - 33'(min_z);
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_s0[i] <= s[i][32:1];
				e_s0[i] <= d[i][32:1];
			end
		end
	end

	function automatic q_t el(input logic [63:0] r, input logic hi_half);
		return hi_half ? r[63:32] : r[31:0];
	endfunction

	q_t p [4];
	logic ps [4];
	q_t lo [4], hi [4];
	logic ls [4];
	for (genvar j = 0; j < 4; j++) begin : g_lane
		aabb_lane u_lane (
			.clk(clk), .adv(adv),
			.c_x(c_s0[0]), .c_y(c_s0[1]), .c_z(c_s0[2]),
			.e_x(e_s0[0]), .e_y(e_s0[1]), .e_z(e_s0[2]),
			.m1(el(m_q[j/2], 1'(j%2))),
			.m2(el(m_q[2 + j/2], 1'(j%2))),
			.m3(el(m_q[4 + j/2], 1'(j%2))),
			.m4(el(m_q[6 + j/2], 1'(j%2))),
			.w_in(p[3]), .w_zero_in(p[3] == 0),
			.p_out(p[j]), .p_sat(ps[j]),
			.lo(lo[j]), .hi(hi[j]), .sat(ls[j])
		);
	end

	// merge: w saturation flag and w_zero travel alongside the lanes
	logic wsat_q [DIV_BITS+2];
	logic wz_q [DIV_BITS+2];
	always_ff @(posedge clk) begin
		if (adv) begin
			wsat_q[0] <= ps[3];
			wz_q[0] <= p[3] == 0;
			for (int k = 1; k < DIV_BITS + 2; k++) begin
				wsat_q[k] <= wsat_q[k-1];
				wz_q[k] <= wz_q[k-1];
			end
		end
	end

	assign out_min_x = lo[0];
	assign out_min_y = lo[1];
	assign out_min_z = lo[2];
	assign out_max_x = hi[0];
	assign out_max_y = hi[1];
	assign out_max_z = hi[2];
	assign saturated = ls[0] | ls[1] | ls[2] | wsat_q[DIV_BITS+1];
	assign w_zero = wz_q[DIV_BITS+1];
endmodule
`default_nettype wire
